// ===== sv/assert_macros.svh =====
// Assertion macros shared by the brush blend RTL.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/srbb_pkg.sv =====
// Package of the soft round brush blend: widths, register codes, types and
// the Q1.30 multiply helper. Depends on nothing.
`default_nettype none

package srbb_pkg;

    // Field and register widths.
    localparam int COORD_W   = 12;
    localparam int RAD_W     = 10;
    localparam int CX_W      = 14;
    localparam int COL_W     = 8;
    localparam int HARD_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [HARD_W-1:0] HARD_RESET = HARD_W'(4096);

    // Geometry.
    localparam int DX_W  = ((COORD_W > CX_W) ? COORD_W : CX_W) + 2;
    localparam int DSQ_W = 2 * DX_W;
    localparam int DIST_W = DSQ_W + 1;
    localparam int RSQ_W = 2 * RAD_W;

    // Square root unit: one result bit per stage.
    localparam int SQ_RAD_W   = 62;
    localparam int SQ_ROOT_W  = 31;
    localparam int SQ_REM_W   = 35;
    localparam int SQ_STEPS   = SQ_ROOT_W;
    localparam int DIST_SHIFT = 32;

    // Distance in Q.16 and the divider.
    localparam int S_W       = RAD_W + 16;
    localparam int DIV_STEPS = S_W;

    // Q1.30 power evaluation.
    localparam int Q_W            = 31;
    localparam int Q30_SHIFT      = 30;
    localparam int ROOT_LEVELS    = 12;
    localparam int SQ_LEVELS      = 4;
    localparam int HARD_ROOT_BITS = 12;
    localparam int POW_STAGES     = (SQ_LEVELS - 1) + HARD_W;
    localparam logic [Q_W-1:0] Q30_ONE = Q_W'(1) << Q30_SHIFT;

    // Alpha in Q0.16 with one extra bit for 1.0.
    localparam int ALPHA_W = 17;
    localparam int ALPHA_SHIFT = Q30_SHIFT - 16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    // Stream widths.
    localparam int IN_DATA_W  = ((2 * COORD_W + 3 * COL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 3 * COL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_X = 3'd0,
        CFG_CENTRE_Y = 3'd1,
        CFG_RADIUS   = 3'd2,
        CFG_RED      = 3'd3,
        CFG_GREEN    = 3'd4,
        CFG_BLUE     = 3'd5,
        CFG_HARDNESS = 3'd6
    } cfg_idx_e;

    typedef struct packed {
        logic signed [CX_W-1:0] centre_x;
        logic signed [CX_W-1:0] centre_y;
        logic [RAD_W-1:0]       radius;
        logic [COL_W-1:0]       red;
        logic [COL_W-1:0]       green;
        logic [COL_W-1:0]       blue;
        logic [HARD_W-1:0]      hardness;
    } cfg_t;

    // Everything an item carries down the pipeline.
    typedef struct packed {
        logic [COL_W-1:0]                 old_red;
        logic [COL_W-1:0]                 old_green;
        logic [COL_W-1:0]                 old_blue;
        logic                             in_disc;
        logic [ROOT_LEVELS:0][Q_W-1:0]    roots;
        logic [SQ_LEVELS-1:0][Q_W-1:0]    sq;
        logic [Q_W-1:0]                   acc;
    } item_t;

    // Q1.30 product, truncated.
    function automatic logic [Q_W-1:0] q30_mul(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        p = a * b;
        return p[Q30_SHIFT+Q_W-1:Q30_SHIFT];
    endfunction

endpackage

`default_nettype wire

// ===== sv/srbb_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, carrying an item.
// Depends on srbb_pkg.
`default_nettype none

module srbb_isqrt (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [srbb_pkg::SQ_RAD_W-1:0]      in_rad,
    input  srbb_pkg::item_t                    in_item,
    output logic                               out_valid,
    output logic [srbb_pkg::SQ_ROOT_W-1:0]     out_root,
    output srbb_pkg::item_t                    out_item
);

    logic                              vld_reg  [srbb_pkg::SQ_STEPS];
    logic [srbb_pkg::SQ_RAD_W-1:0]     rad_reg  [srbb_pkg::SQ_STEPS];
    logic [srbb_pkg::SQ_REM_W-1:0]     rem_reg  [srbb_pkg::SQ_STEPS];
    logic [srbb_pkg::SQ_ROOT_W-1:0]    root_reg [srbb_pkg::SQ_STEPS];
    srbb_pkg::item_t                   item_reg [srbb_pkg::SQ_STEPS];

    genvar i;
    for (i = 0; i < srbb_pkg::SQ_STEPS; i++)
    begin : g_step
        logic                           vld_in;
        logic [srbb_pkg::SQ_RAD_W-1:0]  rad_in;
        logic [srbb_pkg::SQ_REM_W-1:0]  rem_in;
        logic [srbb_pkg::SQ_ROOT_W-1:0] root_in;
        srbb_pkg::item_t                item_in;
        logic [srbb_pkg::SQ_REM_W-1:0]  rem_sh;
        logic [srbb_pkg::SQ_REM_W-1:0]  trial;
        logic                           ge;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign item_in = in_item;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign item_in = item_reg[i-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        assign rem_sh = {rem_in[srbb_pkg::SQ_REM_W-3:0],
                         rad_in[srbb_pkg::SQ_RAD_W-1 -: 2]};
        assign trial  = {{(srbb_pkg::SQ_REM_W-srbb_pkg::SQ_ROOT_W-2){1'b0}},
                         root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_in[srbb_pkg::SQ_ROOT_W-2:0], ge};
                rad_reg[i]  <= {rad_in[srbb_pkg::SQ_RAD_W-3:0], 2'b00};
                item_reg[i] <= item_in;
            end
        end
    end

    assign out_valid = vld_reg[srbb_pkg::SQ_STEPS-1];
    assign out_root  = root_reg[srbb_pkg::SQ_STEPS-1];
    assign out_item  = item_reg[srbb_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== sv/srbb_div.sv =====
// Pipelined restoring divider of the Q.16 distance by the brush radius,
// one quotient bit per stage. Depends on srbb_pkg.
`default_nettype none

module srbb_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [srbb_pkg::RAD_W-1:0]    radius,
    input  logic                          in_valid,
    input  logic [srbb_pkg::S_W-1:0]      in_s,
    input  srbb_pkg::item_t               in_item,
    output logic                          out_valid,
    output logic [srbb_pkg::S_W-1:0]      out_quot,
    output srbb_pkg::item_t               out_item
);

    logic                          vld_reg  [srbb_pkg::DIV_STEPS];
    logic [srbb_pkg::S_W-1:0]      s_reg    [srbb_pkg::DIV_STEPS];
    logic [srbb_pkg::RAD_W-1:0]    rem_reg  [srbb_pkg::DIV_STEPS];
    logic [srbb_pkg::S_W-1:0]      quot_reg [srbb_pkg::DIV_STEPS];
    srbb_pkg::item_t               item_reg [srbb_pkg::DIV_STEPS];

    genvar i;
    for (i = 0; i < srbb_pkg::DIV_STEPS; i++)
    begin : g_step
        logic                        vld_in;
        logic [srbb_pkg::S_W-1:0]    s_in;
        logic [srbb_pkg::RAD_W-1:0]  rem_in;
        logic [srbb_pkg::S_W-1:0]    quot_in;
        srbb_pkg::item_t             item_in;
        logic [srbb_pkg::RAD_W:0]    rem_sh;
        logic [srbb_pkg::RAD_W:0]    diff;
        logic                        ge;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign s_in    = in_s;
            assign rem_in  = '0;
            assign quot_in = '0;
            assign item_in = in_item;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign s_in    = s_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign quot_in = quot_reg[i-1];
            assign item_in = item_reg[i-1];
        end

        assign rem_sh = {rem_in, s_in[srbb_pkg::S_W-1]};
        assign ge     = (rem_sh >= {1'b0, radius});
        assign diff   = rem_sh - {1'b0, radius};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[srbb_pkg::RAD_W-1:0]
                                  : rem_sh[srbb_pkg::RAD_W-1:0];
                quot_reg[i] <= {quot_in[srbb_pkg::S_W-2:0], ge};
                s_reg[i]    <= {s_in[srbb_pkg::S_W-2:0], 1'b0};
                item_reg[i] <= item_in;
            end
        end
    end

    assign out_valid = vld_reg[srbb_pkg::DIV_STEPS-1];
    assign out_quot  = quot_reg[srbb_pkg::DIV_STEPS-1];
    assign out_item  = item_reg[srbb_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== sv/srbb_power.sv =====
// Power pipeline: repeated squares of the base, then one conditional Q1.30
// multiply per hardness bit in rising bit order. Depends on srbb_pkg.
`default_nettype none

module srbb_power (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [srbb_pkg::HARD_W-1:0]    hardness,
    input  logic                           in_valid,
    input  srbb_pkg::item_t                in_item,
    output logic                           out_valid,
    output srbb_pkg::item_t                out_item
);

    logic            vld_reg  [srbb_pkg::POW_STAGES];
    srbb_pkg::item_t item_reg [srbb_pkg::POW_STAGES];

    genvar i;
    for (i = 0; i < srbb_pkg::POW_STAGES; i++)
    begin : g_stage
        logic                      vld_in;
        srbb_pkg::item_t           item_in;
        srbb_pkg::item_t           item_next;

        if (i == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign item_in = in_item;
        end
        else
        begin : g_rest
            assign vld_in  = vld_reg[i-1];
            assign item_in = item_reg[i-1];
        end

        if (i < srbb_pkg::SQ_LEVELS - 1)
        begin : g_square
            // Square chain; the first stage also seeds the accumulator.
            logic [srbb_pkg::Q_W-1:0] sq_src;
            if (i == 0)
            begin : g_seed
                assign sq_src = item_in.roots[0];
            end
            else
            begin : g_chain
                assign sq_src = item_in.sq[i];
            end

            always_comb
            begin
                item_next = item_in;
                if (i == 0)
                begin
                    item_next.sq[0] = item_in.roots[0];
                    item_next.acc   = srbb_pkg::Q30_ONE;
                end
                item_next.sq[i+1] = srbb_pkg::q30_mul(sq_src, sq_src);
            end
        end
        else
        begin : g_mult
            logic [srbb_pkg::Q_W-1:0] factor;
            if (i - srbb_pkg::SQ_LEVELS + 1 < srbb_pkg::HARD_ROOT_BITS)
            begin : g_root
                assign factor = item_in.roots[srbb_pkg::ROOT_LEVELS
                                              - (i - srbb_pkg::SQ_LEVELS + 1)];
            end
            else
            begin : g_pow
                assign factor = item_in.sq[i - srbb_pkg::SQ_LEVELS + 1
                                           - srbb_pkg::HARD_ROOT_BITS];
            end

            always_comb
            begin
                item_next = item_in;
                if (hardness[i - srbb_pkg::SQ_LEVELS + 1])
                begin
                    item_next.acc = srbb_pkg::q30_mul(item_in.acc, factor);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[i] <= item_next;
            end
        end
    end

    assign out_valid = vld_reg[srbb_pkg::POW_STAGES-1];
    assign out_item  = item_reg[srbb_pkg::POW_STAGES-1];

endmodule

`default_nettype wire

// ===== sv/srbb_blend.sv =====
// Two-stage colour blend: alpha times colour difference, then add, truncate
// and clamp. The second stage is the block's output register. Depends on srbb_pkg.
`default_nettype none

module srbb_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  srbb_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  srbb_pkg::item_t               in_item,
    output logic                          out_valid,
    output logic [srbb_pkg::COL_W-1:0]    out_red,
    output logic [srbb_pkg::COL_W-1:0]    out_green,
    output logic [srbb_pkg::COL_W-1:0]    out_blue,
    output logic                          out_inside
);

    logic [srbb_pkg::ALPHA_W-1:0]          alpha_raw;
    logic [srbb_pkg::ALPHA_W-1:0]          alpha;
    logic [2:0][srbb_pkg::COL_W-1:0]       old_col;
    logic [2:0][srbb_pkg::COL_W-1:0]       brush_col;

    logic                                  s1_vld_reg;
    logic                                  s1_inside_reg;
    logic [2:0][srbb_pkg::COL_W-1:0]       s1_old_reg;
    logic signed [26:0]                    s1_prod_reg [3];

    logic                                  s2_vld_reg;
    logic                                  s2_inside_reg;
    logic [2:0][srbb_pkg::COL_W-1:0]       s2_col_reg;

    assign alpha_raw = in_item.acc[srbb_pkg::Q_W-1:srbb_pkg::ALPHA_SHIFT];
    assign old_col   = {in_item.old_blue, in_item.old_green, in_item.old_red};
    assign brush_col = {cfg.blue, cfg.green, cfg.red};

    // Outside pixels blend with alpha zero and so keep their colour.
    always_comb
    begin
        if (!in_item.in_disc)
        begin
            alpha = '0;
        end
        else if ((cfg.radius == '0) || (alpha_raw > srbb_pkg::ALPHA_ONE))
        begin
            alpha = srbb_pkg::ALPHA_ONE;
        end
        else
        begin
            alpha = alpha_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    genvar c;
    for (c = 0; c < 3; c++)
    begin : g_chan
        logic signed [8:0]  diff;
        logic signed [17:0] alpha_s;
        logic signed [26:0] sum;

        assign diff    = $signed({1'b0, brush_col[c]}) - $signed({1'b0, old_col[c]});
        assign alpha_s = $signed({1'b0, alpha});
        assign sum     = $signed({3'b000, s1_old_reg[c], 16'h0000}) + s1_prod_reg[c];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_prod_reg[c] <= alpha_s * diff;
                if (sum[26])
                begin
                    s2_col_reg[c] <= '0;
                end
                else if (sum[25:24] != 2'b00)
                begin
                    s2_col_reg[c] <= '1;
                end
                else
                begin
                    s2_col_reg[c] <= sum[23:16];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_old_reg    <= old_col;
            s1_inside_reg <= in_item.in_disc;
            s2_inside_reg <= s1_inside_reg;
        end
    end

    assign out_valid  = s2_vld_reg;
    assign out_red    = s2_col_reg[0];
    assign out_green  = s2_col_reg[1];
    assign out_blue   = s2_col_reg[2];
    assign out_inside = s2_inside_reg;

endmodule

`default_nettype wire

// ===== sv/soft_round_brush_blend.sv =====
// Top level of the soft round brush blend: configuration registers, distance
// front end and the chain of root, divide, power and blend pipelines.
// Depends on srbb_pkg, srbb_isqrt, srbb_div, srbb_power, srbb_blend, assert_macros.svh.
//
// This block paints one soft round brush dab onto a stream of pixels. Each
// input item is a pixel (column, row, old RGB) and yields exactly one result
// item: the pixel's new RGB and a flag that tells whether it lay inside the
// brush disc. Outside pixels pass through unchanged. Inside pixels are pulled
// toward the paint colour with alpha = (1 - dist/radius)^hardness, evaluated
// in fixed point. A zero radius paints the centre pixel with the full paint
// colour. The block is a single fully pipelined datapath: it accepts one item
// per clock while the output is not stalled, and each item passes through 454
// register stages. The depth is set by the thirteen bit-serial square root
// units (31 stages each) and the 26-stage radius divider. When the output is
// stalled the whole pipeline holds and s_tready drops; nothing is lost or
// repeated. Registers may be written only while no item is in flight.
`default_nettype none

module soft_round_brush_blend (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write port.
    input  logic                              cfg_wen,
    input  logic [srbb_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [srbb_pkg::CFG_W-1:0]        cfg_wdata,
    // Pixel input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit up: pixel_x, pixel_y, old_red, old_green, old_blue.
    input  logic [srbb_pkg::IN_DATA_W-1:0]    s_tdata,
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, lowest bit up: new_red, new_green, new_blue.
    output logic [srbb_pkg::OUT_DATA_W-1:0]   m_tdata,
    // m_tuser: inside_brush.
    output logic [0:0]                        m_tuser
);

`include "assert_macros.svh"

    srbb_pkg::cfg_t                   cfg_reg;
    logic [srbb_pkg::RSQ_W-1:0]       r2_reg;
    logic                             en;

    // Configuration registers. Unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.centre_x <= '0;
            cfg_reg.centre_y <= '0;
            cfg_reg.radius   <= '0;
            cfg_reg.red      <= '0;
            cfg_reg.green    <= '0;
            cfg_reg.blue     <= '0;
            cfg_reg.hardness <= srbb_pkg::HARD_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                srbb_pkg::CFG_CENTRE_X: cfg_reg.centre_x <= cfg_wdata[srbb_pkg::CX_W-1:0];
                srbb_pkg::CFG_CENTRE_Y: cfg_reg.centre_y <= cfg_wdata[srbb_pkg::CX_W-1:0];
                srbb_pkg::CFG_RADIUS:   cfg_reg.radius   <= cfg_wdata[srbb_pkg::RAD_W-1:0];
                srbb_pkg::CFG_RED:      cfg_reg.red      <= cfg_wdata[srbb_pkg::COL_W-1:0];
                srbb_pkg::CFG_GREEN:    cfg_reg.green    <= cfg_wdata[srbb_pkg::COL_W-1:0];
                srbb_pkg::CFG_BLUE:     cfg_reg.blue     <= cfg_wdata[srbb_pkg::COL_W-1:0];
                srbb_pkg::CFG_HARDNESS: cfg_reg.hardness <= cfg_wdata[srbb_pkg::HARD_W-1:0];
                default:                ;
            endcase
        end
    end

    // The squared radius is registered from the radius and is ready well before the
    // first item after a write reaches the compare.
    always_ff @(posedge clk)
    begin
        r2_reg <= cfg_reg.radius * cfg_reg.radius;
    end

    // The whole pipeline advances unless a finished result is waiting.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------------------------------------------------------
    // Front end: offsets, squares, squared distance and the disc test.
    // ---------------------------------------------------------------
    logic [srbb_pkg::COORD_W-1:0]        px;
    logic [srbb_pkg::COORD_W-1:0]        py;
    logic signed [srbb_pkg::DX_W-1:0]    dx_next;
    logic signed [srbb_pkg::DX_W-1:0]    dy_next;
    srbb_pkg::item_t                     item_next;

    logic                                g1_vld_reg;
    logic signed [srbb_pkg::DX_W-1:0]    g1_dx_reg;
    logic signed [srbb_pkg::DX_W-1:0]    g1_dy_reg;
    srbb_pkg::item_t                     g1_item_reg;

    logic                                g2_vld_reg;
    logic [srbb_pkg::DSQ_W-1:0]          g2_dx2_reg;
    logic [srbb_pkg::DSQ_W-1:0]          g2_dy2_reg;
    srbb_pkg::item_t                     g2_item_reg;

    logic [srbb_pkg::DIST_W-1:0]         dist2;
    logic                                g3_vld_reg;
    logic [srbb_pkg::RSQ_W-1:0]          g3_dist_reg;
    srbb_pkg::item_t                     g3_item_next;
    srbb_pkg::item_t                     g3_item_reg;

    logic signed [srbb_pkg::DSQ_W-1:0]   dx_sq;
    logic signed [srbb_pkg::DSQ_W-1:0]   dy_sq;

    assign px = s_tdata[srbb_pkg::COORD_W-1:0];
    assign py = s_tdata[2*srbb_pkg::COORD_W-1:srbb_pkg::COORD_W];

    assign dx_next = $signed({{(srbb_pkg::DX_W-srbb_pkg::COORD_W){1'b0}}, px})
                   - $signed({{(srbb_pkg::DX_W-srbb_pkg::CX_W){cfg_reg.centre_x[srbb_pkg::CX_W-1]}},
                              cfg_reg.centre_x});
    assign dy_next = $signed({{(srbb_pkg::DX_W-srbb_pkg::COORD_W){1'b0}}, py})
                   - $signed({{(srbb_pkg::DX_W-srbb_pkg::CX_W){cfg_reg.centre_y[srbb_pkg::CX_W-1]}},
                              cfg_reg.centre_y});

    always_comb
    begin
        item_next           = '0;
        item_next.old_red   = s_tdata[2*srbb_pkg::COORD_W +: srbb_pkg::COL_W];
        item_next.old_green = s_tdata[2*srbb_pkg::COORD_W + srbb_pkg::COL_W +: srbb_pkg::COL_W];
        item_next.old_blue  = s_tdata[2*srbb_pkg::COORD_W + 2*srbb_pkg::COL_W +: srbb_pkg::COL_W];
    end

    assign dx_sq = g1_dx_reg * g1_dx_reg;
    assign dy_sq = g1_dy_reg * g1_dy_reg;
    assign dist2 = {1'b0, g2_dx2_reg} + {1'b0, g2_dy2_reg};

    // The disc test result joins the item as it enters the third stage.
    always_comb
    begin
        g3_item_next         = g2_item_reg;
        g3_item_next.in_disc = (dist2 <= {{(srbb_pkg::DIST_W-srbb_pkg::RSQ_W){1'b0}}, r2_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_vld_reg <= 1'b0;
            g2_vld_reg <= 1'b0;
            g3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            g1_vld_reg <= s_tvalid;
            g2_vld_reg <= g1_vld_reg;
            g3_vld_reg <= g2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_dx_reg   <= dx_next;
            g1_dy_reg   <= dy_next;
            g1_item_reg <= item_next;
            g2_dx2_reg  <= dx_sq;
            g2_dy2_reg  <= dy_sq;
            g2_item_reg <= g1_item_reg;
            // Only inside pixels need an exact distance, and theirs fits
            // within the squared radius width.
            g3_dist_reg <= dist2[srbb_pkg::RSQ_W-1:0];
            g3_item_reg <= g3_item_next;
        end
    end

    // ---------------------------------------------------------------
    // Distance in Q.16, then divided by the radius.
    // ---------------------------------------------------------------
    logic                              ds_vld;
    logic [srbb_pkg::SQ_ROOT_W-1:0]    ds_root;
    srbb_pkg::item_t                   ds_item;
    logic                              dv_vld;
    logic [srbb_pkg::S_W-1:0]          dv_quot;
    srbb_pkg::item_t                   dv_item;

    srbb_isqrt u_dist_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g3_vld_reg),
        .in_rad    ({{(srbb_pkg::SQ_RAD_W-srbb_pkg::RSQ_W-srbb_pkg::DIST_SHIFT){1'b0}},
                     g3_dist_reg, {srbb_pkg::DIST_SHIFT{1'b0}}}),
        .in_item   (g3_item_reg),
        .out_valid (ds_vld),
        .out_root  (ds_root),
        .out_item  (ds_item)
    );

    srbb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .radius    (cfg_reg.radius),
        .in_valid  (ds_vld),
        .in_s      (ds_root[srbb_pkg::S_W-1:0]),
        .in_item   (ds_item),
        .out_valid (dv_vld),
        .out_quot  (dv_quot),
        .out_item  (dv_item)
    );

    // Base = 1 - dist/radius in Q0.16, widened to Q1.30 as the first root.
    logic [srbb_pkg::ALPHA_W-1:0]  t_clamp;
    logic [srbb_pkg::ALPHA_W-1:0]  base;
    logic                          bs_vld_reg;
    srbb_pkg::item_t               bs_item_next;
    srbb_pkg::item_t               bs_item_reg;

    assign t_clamp = (dv_quot > srbb_pkg::S_W'(srbb_pkg::ALPHA_ONE))
                   ? srbb_pkg::ALPHA_ONE : dv_quot[srbb_pkg::ALPHA_W-1:0];
    assign base    = srbb_pkg::ALPHA_ONE - t_clamp;

    always_comb
    begin
        bs_item_next          = dv_item;
        bs_item_next.roots[0] = {base, {srbb_pkg::ALPHA_SHIFT{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            bs_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bs_item_reg <= bs_item_next;
        end
    end

    // ---------------------------------------------------------------
    // Twelve successive square roots of the base for the fraction bits.
    // ---------------------------------------------------------------
    logic            rt_vld  [srbb_pkg::ROOT_LEVELS+1];
    srbb_pkg::item_t rt_item [srbb_pkg::ROOT_LEVELS+1];

    assign rt_vld[0]  = bs_vld_reg;
    assign rt_item[0] = bs_item_reg;

    genvar j;
    for (j = 1; j <= srbb_pkg::ROOT_LEVELS; j++)
    begin : g_root
        logic [srbb_pkg::SQ_ROOT_W-1:0] root_out;
        srbb_pkg::item_t                item_out;

        srbb_isqrt u_root_sqrt (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (rt_vld[j-1]),
            .in_rad    ({{(srbb_pkg::SQ_RAD_W-srbb_pkg::Q_W-srbb_pkg::Q30_SHIFT){1'b0}},
                         rt_item[j-1].roots[j-1], {srbb_pkg::Q30_SHIFT{1'b0}}}),
            .in_item   (rt_item[j-1]),
            .out_valid (rt_vld[j]),
            .out_root  (root_out),
            .out_item  (item_out)
        );

        always_comb
        begin
            rt_item[j]          = item_out;
            rt_item[j].roots[j] = root_out[srbb_pkg::Q_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Power and blend.
    // ---------------------------------------------------------------
    logic            pw_vld;
    srbb_pkg::item_t pw_item;

    srbb_power u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .hardness  (cfg_reg.hardness),
        .in_valid  (rt_vld[srbb_pkg::ROOT_LEVELS]),
        .in_item   (rt_item[srbb_pkg::ROOT_LEVELS]),
        .out_valid (pw_vld),
        .out_item  (pw_item)
    );

    srbb_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg_reg),
        .in_valid   (pw_vld),
        .in_item    (pw_item),
        .out_valid  (m_tvalid),
        .out_red    (m_tdata[srbb_pkg::COL_W-1:0]),
        .out_green  (m_tdata[2*srbb_pkg::COL_W-1:srbb_pkg::COL_W]),
        .out_blue   (m_tdata[3*srbb_pkg::COL_W-1:2*srbb_pkg::COL_W]),
        .out_inside (m_tuser[0])
    );

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    // A waiting result freezes the front of the pipeline.
    `ASSERT_IMPLIES(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `ASSERT_NEXT(a_stall_holds_front, m_tvalid && !m_tready, $stable(g1_vld_reg), "front stage moved during a stall")
    // A full-strength dab paints exactly the brush colour; only the red channel is checked.
    `ASSERT_IMPLIES(a_full_alpha_red, m_tvalid && m_tuser[0] && (cfg_reg.radius == '0 || cfg_reg.hardness == '0), m_tdata[srbb_pkg::COL_W-1:0] == cfg_reg.red, "full alpha pixel not brush red")

endmodule

`default_nettype wire
